>>> rtl/tp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tp_pkg
// shared types and constants of the turtle plotter
// ----------------------------------------------------------------------------
package tp_pkg;

  localparam int FLOOR_ROWS = 32;
  localparam int FLOOR_COLS = 64;
  localparam int ROW_W      = $clog2(FLOOR_ROWS);
  localparam int COL_W      = $clog2(FLOOR_COLS);
  // a display request carries at most 32 rows
  localparam int DISP_ROWS  = (FLOOR_ROWS < 32) ? FLOOR_ROWS : 32;

  typedef enum logic [2:0] {
    CMD_PEN_UP,
    CMD_PEN_DOWN,
    CMD_RIGHT,
    CMD_LEFT,
    CMD_MOVE,
    CMD_DISPLAY,
    CMD_END,
    CMD_INVALID
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_DONE,
    STAT_ROW,
    STAT_INVALID,
    STAT_HALTED
  } status_t;

  typedef enum logic [1:0] {
    HEAD_NORTH,
    HEAD_EAST,
    HEAD_SOUTH,
    HEAD_WEST
  } heading_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIN,
    S_MV_RD,
    S_MV_STEP,
    S_DSP_RD,
    S_DSP_EMIT
  } state_t;

  typedef struct packed {
    logic             rd_en;
    logic             wr_en;
    logic [ROW_W-1:0] addr;
  } mem_req_t;

  typedef struct packed {
    status_t     status;
    logic [63:0] row_bits;
    logic [4:0]  row_index;
    logic        last;
    logic [4:0]  pos_row;
    logic [5:0]  pos_col;
    heading_t    heading;
    logic        pen_down;
  } result_t;

endpackage

>>> rtl/turtle_plotter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// turtle_plotter_core
// turtle graphics interpreter drawing on a one-bit floor bitmap
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid / in_ready) carries one command request with
//   command and distance. output channel (out_valid / out_ready) carries
//   results: every request gives one result, a display gives one result per
//   floor row (rows 0 up, last set on the final row).
// timing
//   one request is in work at a time; in_ready is high only while idle.
//   pen, turn, end and invalid requests: the result is loaded from S_FIN.
//   move with pen up: one step per cycle. move with pen down: one step per
//   cycle along a row plus a row fetch (S_MV_RD) each time the row changes,
//   so north and south walks fetch a row before every step. the walk and the
//   single read/write port of the floor memory set this pattern.
//   display: per row a memory read (S_DSP_RD), then an emit (S_DSP_EMIT).
// reset
//   synchronous rst clears position, heading (south), pen (up), halted and
//   the row valid bits of the floor memory; rows never written read as clear,
//   so no clearing pass is needed and requests are taken right after reset.
// stall
//   results sit in an output register; while out_ready is low the sequencer
//   waits before loading the next result, nothing is dropped.
// ----------------------------------------------------------------------------
module turtle_plotter_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  command,
  input  logic [7:0]  distance,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [63:0] row_bits,
  output logic [4:0]  row_index,
  output logic        last,
  output logic [4:0]  pos_row,
  output logic [5:0]  pos_col,
  output logic [1:0]  heading,
  output logic        pen_down
);
  import tp_pkg::*;

  mem_req_t              mem_req;
  logic [FLOOR_COLS-1:0] wr_data;
  logic [FLOOR_COLS-1:0] rd_data;
  logic                  out_free;
  logic                  res_load;
  result_t               res;
  result_t               res_q;

  // sequencer owns the turtle state and drives the floor memory
  tp_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .command  (command),
    .distance (distance),
    .out_free (out_free),
    .res_load (res_load),
    .res      (res),
    .mem_req  (mem_req),
    .wr_data  (wr_data),
    .rd_data  (rd_data)
  );

  tp_floor_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .req     (mem_req),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  // output register: free when empty or being taken this cycle
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_q <= res;
    end
  end

  assign status    = res_q.status;
  assign row_bits  = res_q.row_bits;
  assign row_index = res_q.row_index;
  assign last      = res_q.last;
  assign pos_row   = res_q.pos_row;
  assign pos_col   = res_q.pos_col;
  assign heading   = res_q.heading;
  assign pen_down  = res_q.pen_down;

endmodule

>>> rtl/tp_floor_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tp_floor_mem
// floor bitmap, one row per entry, registered read, row valid bits
// ----------------------------------------------------------------------------
module tp_floor_mem (
  input  logic                          clk,
  input  logic                          rst,
  input  tp_pkg::mem_req_t              req,
  input  logic [tp_pkg::FLOOR_COLS-1:0] wr_data,
  output logic [tp_pkg::FLOOR_COLS-1:0] rd_data
);
  import tp_pkg::*;

  logic [FLOOR_COLS-1:0] ram [FLOOR_ROWS];
  logic [FLOOR_ROWS-1:0] row_ok;
  logic [FLOOR_COLS-1:0] rd_q;
  logic                  rd_ok;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      ram[req.addr] <= wr_data;
    end
    if (req.rd_en) begin
      rd_q <= ram[req.addr];
    end
  end

  // rows never written read as cleared
  always_ff @(posedge clk) begin
    if (rst) begin
      row_ok <= '0;
      rd_ok  <= 1'b0;
    end else begin
      if (req.wr_en) begin
        row_ok[req.addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_ok <= row_ok[req.addr];
      end
    end
  end

  assign rd_data = rd_ok ? rd_q : '0;

endmodule

>>> rtl/tp_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tp_seq
// command sequencer: turtle state, move walk and display sweep
// ----------------------------------------------------------------------------
module tp_seq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0]                    command,
  input  logic [7:0]                    distance,
  input  logic                          out_free,
  output logic                          res_load,
  output tp_pkg::result_t               res,
  output tp_pkg::mem_req_t              mem_req,
  output logic [tp_pkg::FLOOR_COLS-1:0] wr_data,
  input  logic [tp_pkg::FLOOR_COLS-1:0] rd_data
);
  import tp_pkg::*;

  state_t                state, state_next;
  logic [ROW_W-1:0]      cur_row, cur_row_next;
  logic [COL_W-1:0]      cur_col, cur_col_next;
  heading_t              cur_heading, cur_heading_next;
  logic                  pen_state, pen_state_next;
  logic                  halted, halted_next;
  logic [7:0]            remaining, remaining_next;
  status_t               fin_status, fin_status_next;
  logic [FLOOR_COLS-1:0] row_buf, row_buf_next;
  logic                  fresh, fresh_next;
  logic [ROW_W-1:0]      drow, drow_next;

  logic [ROW_W-1:0]      step_row;
  logic [COL_W-1:0]      step_col;
  logic [FLOOR_COLS-1:0] marked;
  logic                  last_step;
  logic                  row_moved;
  logic                  dsp_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cur_row     <= '0;
      cur_col     <= '0;
      cur_heading <= HEAD_SOUTH;
      pen_state   <= 1'b0;
      halted      <= 1'b0;
      fresh       <= 1'b0;
      drow        <= '0;
    end else begin
      state       <= state_next;
      cur_row     <= cur_row_next;
      cur_col     <= cur_col_next;
      cur_heading <= cur_heading_next;
      pen_state   <= pen_state_next;
      halted      <= halted_next;
      fresh       <= fresh_next;
      drow        <= drow_next;
    end
  end

  always_ff @(posedge clk) begin
    remaining  <= remaining_next;
    fin_status <= fin_status_next;
    row_buf    <= row_buf_next;
  end

  // one step with the border clamp
  always_comb begin
    step_row = cur_row;
    step_col = cur_col;
    case (cur_heading)
      HEAD_NORTH: if (cur_row != '0) step_row = cur_row - 1'b1;
      HEAD_SOUTH: if (cur_row != ROW_W'(FLOOR_ROWS - 1)) step_row = cur_row + 1'b1;
      HEAD_EAST:  if (cur_col != COL_W'(FLOOR_COLS - 1)) step_col = cur_col + 1'b1;
      HEAD_WEST:  if (cur_col != '0) step_col = cur_col - 1'b1;
      default:    step_row = cur_row;
    endcase
  end

  assign marked    = (fresh ? rd_data : row_buf) | (FLOOR_COLS'(1) << cur_col);
  assign last_step = (remaining == 8'd1);
  assign row_moved = (step_row != cur_row);
  assign dsp_last  = (drow == ROW_W'(DISP_ROWS - 1));
  assign wr_data   = marked;

  always_comb begin
    state_next       = state;
    cur_row_next     = cur_row;
    cur_col_next     = cur_col;
    cur_heading_next = cur_heading;
    pen_state_next   = pen_state;
    halted_next      = halted;
    remaining_next   = remaining;
    fin_status_next  = fin_status;
    row_buf_next     = row_buf;
    fresh_next       = fresh;
    drow_next        = drow;
    in_ready         = 1'b0;
    res_load         = 1'b0;
    mem_req.rd_en    = 1'b0;
    mem_req.wr_en    = 1'b0;
    mem_req.addr     = cur_row;

    res.status    = fin_status;
    res.row_bits  = '0;
    res.row_index = '0;
    res.last      = 1'b1;
    res.pos_row   = 5'(cur_row);
    res.pos_col   = 6'(cur_col);
    res.heading   = cur_heading;
    res.pen_down  = pen_state;

    case (state)
      S_IDLE: begin
        in_ready        = 1'b1;
        fin_status_next = STAT_DONE;
        remaining_next  = distance;
        if (in_valid) begin
          state_next = S_FIN;
          if (halted) begin
            fin_status_next = STAT_HALTED;
          end else begin
            case (cmd_t'(command))
              CMD_PEN_UP:   pen_state_next = 1'b0;
              CMD_PEN_DOWN: pen_state_next = 1'b1;
              CMD_RIGHT:    cur_heading_next = heading_t'(cur_heading + 2'd1);
              CMD_LEFT:     cur_heading_next = heading_t'(cur_heading - 2'd1);
              CMD_MOVE: begin
                if (distance == 8'd0) begin
                  state_next = S_FIN;
                end else if (pen_state) begin
                  state_next = S_MV_RD;
                end else begin
                  fresh_next = 1'b0;
                  state_next = S_MV_STEP;
                end
              end
              CMD_DISPLAY: begin
                drow_next  = '0;
                state_next = S_DSP_RD;
              end
              CMD_END: halted_next = 1'b1;
              default: begin
                halted_next     = 1'b1;
                fin_status_next = STAT_INVALID;
              end
            endcase
          end
        end
      end

      S_FIN: begin
        if (out_free) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      // fetch the row under the turtle before marking on it
      S_MV_RD: begin
        mem_req.rd_en = 1'b1;
        fresh_next    = 1'b1;
        state_next    = S_MV_STEP;
      end

      S_MV_STEP: begin
        fresh_next     = 1'b0;
        row_buf_next   = marked;
        cur_row_next   = step_row;
        cur_col_next   = step_col;
        remaining_next = remaining - 8'd1;
        if (pen_state && (last_step || row_moved)) begin
          mem_req.wr_en = 1'b1;
        end
        if (last_step) begin
          state_next = S_FIN;
        end else if (pen_state && row_moved) begin
          state_next = S_MV_RD;
        end
      end

      S_DSP_RD: begin
        mem_req.rd_en = 1'b1;
        mem_req.addr  = drow;
        state_next    = S_DSP_EMIT;
      end

      S_DSP_EMIT: begin
        res.status    = STAT_ROW;
        res.row_bits  = 64'(rd_data);
        res.row_index = 5'(drow);
        res.last      = dsp_last;
        if (out_free) begin
          res_load = 1'b1;
          if (dsp_last) begin
            state_next = S_IDLE;
          end else begin
            drow_next  = drow + 1'b1;
            state_next = S_DSP_RD;
          end
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> rtl/tp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tp_checker
// port-level checks of the turtle plotter, bound to the top level
// ----------------------------------------------------------------------------
module tp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [63:0] row_bits,
  input logic [4:0]  row_index,
  input logic        last
);
  import tp_pkg::*;

  // a taken request drops in_ready in the next cycle
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while previous one still in work");

  // only floor row results carry row data
  a_row_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STAT_ROW |-> row_bits == '0 && row_index == '0)
    else $error("row data on a non-row result");

  // single results always close their request
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STAT_ROW |-> last)
    else $error("single result without last");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(row_bits) && $stable(status))
    else $error("result changed while stalled");

endmodule

bind turtle_plotter_core tp_checker u_tp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .status    (status),
  .row_bits  (row_bits),
  .row_index (row_index),
  .last      (last)
);
